@@ hw/rtl/sfpcg_pkg.sv @@
package sfpcg_pkg;

    // Field widths
    localparam int ANG_W   = 14;
    localparam int TRQ_W   = 9;
    localparam int COIL_W  = 9;
    localparam int FILT_W  = 16;
    localparam int ROM_W   = 14;
    localparam int CFG_W   = 14;
    localparam int REG_IDX_W = 1;

    // Stream widths (tdata byte aligned)
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;

    // Defaults for the top-level parameters
    localparam int DEF_POLE_PAIRS   = 50;
    localparam int DEF_SINE_ENTRIES = 1025;

    // Electrical period and quarter points
    localparam int PERIOD   = 16384;
    localparam int QUARTER  = 4096;
    localparam int HALF     = 8192;
    localparam int THREE_Q  = 12288;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_NULL_ANGLE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_TRIM = 1'b1;

    // Sine table generation: pi/2 in Q2.30 and Taylor divisors (2k)(2k+1)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [13] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic filt_en;
        logic phase_en;
        logic addr_en;
        logic rom_en;
        logic mul_en;
        logic sel_cos;
        logic out_load;
    } dp_cmd_t;

endpackage

@@ hw/rtl/sfpcg_ctrl.sv @@
module sfpcg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sfpcg_pkg::dp_cmd_t   cmd
);
    import sfpcg_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FILT   = 4'd1;
    localparam logic [3:0] ST_PHASE  = 4'd2;
    localparam logic [3:0] ST_ADDR_S = 4'd3;
    localparam logic [3:0] ST_ROM_S  = 4'd4;
    localparam logic [3:0] ST_MUL_S  = 4'd5;
    localparam logic [3:0] ST_ADDR_C = 4'd6;
    localparam logic [3:0] ST_ROM_C  = 4'd7;
    localparam logic [3:0] ST_MUL_C  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       slot_free;

    assign slot_free = !valid_reg || out_ready;
    assign in_ready  = aresetn && (state_reg == ST_IDLE);
    assign out_valid = valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_FILT;
                end
            end
            ST_FILT: begin
                cmd.filt_en = 1'b1;
                state_next  = ST_PHASE;
            end
            ST_PHASE: begin
                cmd.phase_en = 1'b1;
                state_next   = ST_ADDR_S;
            end
            ST_ADDR_S: begin
                cmd.addr_en = 1'b1;
                state_next  = ST_ROM_S;
            end
            ST_ROM_S: begin
                cmd.rom_en = 1'b1;
                state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ADDR_C;
            end
            ST_ADDR_C: begin
                cmd.addr_en = 1'b1;
                cmd.sel_cos = 1'b1;
                state_next  = ST_ROM_C;
            end
            ST_ROM_C: begin
                cmd.rom_en  = 1'b1;
                cmd.sel_cos = 1'b1;
                state_next  = ST_MUL_C;
            end
            ST_MUL_C: begin
                cmd.sel_cos = 1'b1;
                // hold until the output slot frees up
                if (slot_free) begin
                    cmd.mul_en   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ hw/rtl/sfpcg_datapath.sv @@
module sfpcg_datapath #(
    parameter int POLE_PAIRS   = sfpcg_pkg::DEF_POLE_PAIRS,
    parameter int SINE_ENTRIES = sfpcg_pkg::DEF_SINE_ENTRIES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sfpcg_pkg::dp_cmd_t                  cmd,
    input  logic [sfpcg_pkg::ANG_W-1:0]         angle_now,
    input  logic [sfpcg_pkg::ANG_W-1:0]         angle_before,
    input  logic                                rollover,
    input  logic signed [sfpcg_pkg::TRQ_W-1:0]  torque_level,
    input  logic                                cfg_wr_en,
    input  logic [sfpcg_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [sfpcg_pkg::CFG_W-1:0]         cfg_wdata,
    output logic signed [sfpcg_pkg::COIL_W-1:0] coil_a,
    output logic signed [sfpcg_pkg::COIL_W-1:0] coil_b
);
    import sfpcg_pkg::*;

    localparam int PP_W     = $clog2(POLE_PAIRS + 1);
    localparam int BASE_W   = FILT_W + 1;
    localparam int PH_W     = BASE_W + PP_W + 1;
    localparam int IDX_W    = $clog2(SINE_ENTRIES);
    localparam int Q_W      = 13;
    localparam int IPROD_W  = Q_W + IDX_W + 1;
    localparam int MR_W     = 15;
    localparam int PROD_W   = ROM_W + 1 + TRQ_W;

    typedef logic [ROM_W-1:0] rom_t [SINE_ENTRIES];

    // Quarter sine, 8192 full scale, Taylor series in Q2.30
    function automatic rom_t build_rom();
        rom_t               r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] acc;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_ENTRIES - 1);
            x2   = (x * x) >> 30;
            term = x;
            acc  = signed'(x);
            for (int k = 0; k < 13; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if (k[0] == 1'b0) begin
                    acc = acc - signed'(term);
                end else begin
                    acc = acc + signed'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            v = ((unsigned'(acc) * 64'd8192) + (64'd1 << 29)) >> 30;
            if (v > 64'd8192) begin
                v = 64'd8192;
            end
            r[i] = v[ROM_W-1:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Configuration
    logic [ANG_W-1:0]        null_angle_reg;
    logic [CFG_W-1:0]        phase_trim_reg;

    // Item registers
    logic [ANG_W-1:0]        now_reg;
    logic [ANG_W-1:0]        before_reg;
    logic                    roll_reg;
    logic signed [TRQ_W-1:0] torque_reg;
    logic [FILT_W-1:0]       filt_reg;
    logic [FILT_W-1:0]       off_reg;
    logic signed [PH_W-1:0]  phase_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic                    sign_reg;
    logic                    rsign_reg;
    logic [ROM_W-1:0]        rom_reg;
    logic [COIL_W-1:0]       coil_a_reg;
    logic [COIL_W-1:0]       out_a_reg;
    logic [COIL_W-1:0]       out_b_reg;

    // Filter and offset
    logic [FILT_W-1:0]       diff;
    logic signed [FILT_W:0]  fsum;
    logic signed [FILT_W:0]  fround;
    logic [FILT_W-1:0]       filt_new;
    logic [FILT_W-1:0]       off_new;
    logic signed [BASE_W-1:0] base;
    logic signed [PP_W:0]    pp_s;

    assign diff = roll_reg ? filt_reg
                           : {2'b00, now_reg} - {2'b00, before_reg};
    assign fsum   = $signed({diff[FILT_W-1], diff}) + $signed({filt_reg[FILT_W-1], filt_reg});
    // truncate toward zero: bias negative sums by one before halving
    assign fround = fsum + $signed({{FILT_W{1'b0}}, fsum[FILT_W]});
    assign filt_new = fround[FILT_W:1];
    assign off_new  = {2'b00, now_reg} - {2'b00, null_angle_reg}
                    - {{(FILT_W-CFG_W){phase_trim_reg[CFG_W-1]}}, phase_trim_reg};
    assign base = $signed({off_reg[FILT_W-1], off_reg}) + $signed({filt_reg, 1'b0});
    assign pp_s = $signed({1'b0, PP_W'(POLE_PAIRS)});

    // Phase reduction and table address
    logic [PH_W:0]    psel;
    logic             pneg;
    logic [PH_W:0]    mag;
    logic [PH_W:0]    mag_m1;
    logic [MR_W-1:0]  mr;
    logic [MR_W-1:0]  qoff;
    logic [Q_W-1:0]   q;
    logic             mirror;
    logic             qneg;
    logic [IPROD_W-1:0] iprod;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] addr_new;

    assign psel   = cmd.sel_cos ? {phase_reg[PH_W-1], phase_reg} + (PH_W+1)'(QUARTER)
                                : {phase_reg[PH_W-1], phase_reg};
    assign pneg   = psel[PH_W];
    assign mag    = pneg ? (~psel + 1'b1) : psel;
    assign mag_m1 = mag - 1'b1;
    // fold onto 1..16384, keeping zero as zero
    assign mr     = (mag == '0) ? '0 : {1'b0, mag_m1[ANG_W-1:0]} + 1'b1;

    always_comb begin
        if (mr <= MR_W'(QUARTER)) begin
            qoff = '0;
            mirror = 1'b0;
            qneg = 1'b0;
        end else if (mr <= MR_W'(HALF)) begin
            qoff = MR_W'(QUARTER);
            mirror = 1'b1;
            qneg = 1'b0;
        end else if (mr <= MR_W'(THREE_Q)) begin
            qoff = MR_W'(HALF);
            mirror = 1'b0;
            qneg = 1'b1;
        end else begin
            qoff = MR_W'(THREE_Q);
            mirror = 1'b1;
            qneg = 1'b1;
        end
    end

    assign q        = Q_W'(mr - qoff);
    assign iprod    = IPROD_W'(q) * IPROD_W'(SINE_ENTRIES - 1) + IPROD_W'(QUARTER / 2);
    assign idx      = iprod[12 +: IDX_W];
    assign addr_new = mirror ? IDX_W'(SINE_ENTRIES - 1) - idx : idx;

    // Scale by torque
    logic signed [ROM_W:0]    rval;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] padj;
    logic signed [PROD_W-1:0] pscaled;
    logic [COIL_W-1:0]        coil_new;

    assign rval    = rsign_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});
    assign prod    = torque_reg * rval;
    assign padj    = prod + $signed({{(PROD_W-13){1'b0}}, {13{prod[PROD_W-1]}}});
    assign pscaled = padj >>> 13;

    always_comb begin
        if (pscaled > $signed(PROD_W'(255))) begin
            coil_new = COIL_W'(255);
        end else if (pscaled < -$signed(PROD_W'(255))) begin
            coil_new = COIL_W'(-255);
        end else begin
            coil_new = pscaled[COIL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            null_angle_reg <= '0;
            phase_trim_reg <= '0;
            filt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NULL_ANGLE: null_angle_reg <= cfg_wdata[ANG_W-1:0];
                    REG_PHASE_TRIM: phase_trim_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.filt_en) begin
                filt_reg <= filt_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            now_reg    <= angle_now;
            before_reg <= angle_before;
            roll_reg   <= rollover;
            torque_reg <= torque_level;
        end
        if (cmd.filt_en) begin
            off_reg <= off_new;
        end
        if (cmd.phase_en) begin
            phase_reg <= base * pp_s;
        end
        if (cmd.addr_en) begin
            addr_reg <= addr_new;
            // coil_a takes the negated sine
            sign_reg <= qneg ^ pneg ^ ~cmd.sel_cos;
        end
        if (cmd.rom_en) begin
            rom_reg   <= SINE_ROM[addr_reg];
            rsign_reg <= sign_reg;
        end
        if (cmd.mul_en && !cmd.sel_cos) begin
            coil_a_reg <= coil_new;
        end
        if (cmd.out_load) begin
            out_a_reg <= coil_a_reg;
            out_b_reg <= coil_new;
        end
    end

    assign coil_a = out_a_reg;
    assign coil_b = out_b_reg;

endmodule

@@ hw/rtl/stepper_foc_phase_current_gen_core.sv @@
// Flow: the input is taken only while idle, so a new item waits until the last
// is through: accept, filter, phase multiply, then two passes (sine, cosine) of
// table address, table read and torque multiply; the result is registered onto
// m_tvalid. A result still held by m_tready stalls the last pass until it drains.
// Reset: aresetn is synchronous, active low; it clears the controller, the
// filtered step and both configuration registers. The sine table is constant.
module stepper_foc_phase_current_gen_core #(
    parameter int POLE_PAIRS   = sfpcg_pkg::DEF_POLE_PAIRS,
    parameter int SINE_ENTRIES = sfpcg_pkg::DEF_SINE_ENTRIES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [13:0] angle_now, [27:14] angle_before, [36:28] torque_level, rest zero
    input  logic [sfpcg_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] rollover
    input  logic [sfpcg_pkg::S_TUSER_W-1:0]     s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [8:0] coil_a, [17:9] coil_b, rest zero
    output logic [sfpcg_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [sfpcg_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [sfpcg_pkg::CFG_W-1:0]         cfg_wdata
);
    import sfpcg_pkg::*;

    dp_cmd_t                  cmd;
    logic signed [COIL_W-1:0] coil_a;
    logic signed [COIL_W-1:0] coil_b;

    // Controller: sequences one item; the output register lets the next
    // item transfer in while a finished result still waits downstream.
    sfpcg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    // Datapath: step filter, electrical phase, quadrant fold, quarter-wave
    // table lookup and torque scaling with saturation.
    sfpcg_datapath #(
        .POLE_PAIRS   (POLE_PAIRS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .angle_now    (s_tdata[13:0]),
        .angle_before (s_tdata[27:14]),
        .rollover     (s_tuser[0]),
        .torque_level (s_tdata[36:28]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .coil_a       (coil_a),
        .coil_b       (coil_b)
    );

    // Pack coil_a low, coil_b above it, pad to whole bytes
    assign m_tdata = {{(M_TDATA_W - 2*COIL_W){1'b0}}, coil_b, coil_a};

endmodule

@@ sim/stepper_foc_coil_checker.sv @@
module stepper_foc_coil_checker #(
    parameter int POLE_PAIRS   = sfpcg_pkg::DEF_POLE_PAIRS,
    parameter int SINE_ENTRIES = sfpcg_pkg::DEF_SINE_ENTRIES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [13:0] angle_now, [27:14] angle_before, [36:28] torque_level, rest zero
    input  logic [sfpcg_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] rollover
    input  logic [sfpcg_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [8:0] coil_a, [17:9] coil_b, rest zero
    input  logic [sfpcg_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [sfpcg_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [sfpcg_pkg::CFG_W-1:0]     cfg_wdata,
    output int                              fail_count,
    output int                              checked_count,
    output int                              pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import sfpcg_pkg::*;

    typedef struct packed {
        logic signed [COIL_W-1:0] coil_b;
        logic signed [COIL_W-1:0] coil_a;
    } coil_pair_t;

    logic [ROM_W-1:0] sine_table [SINE_ENTRIES];
    coil_pair_t       expected_coils [$];

    int               null_angle;
    int               phase_trim;
    int               filtered_step;
    int               n_fail;
    int               n_checked;
    coil_pair_t       want;

    // Quarter-wave table: Taylor series in unsigned Q2.30, rounded to x8192.
    initial begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            x    = (HALF_PI_Q30 * i) / (SINE_ENTRIES - 1);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 13; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = ($unsigned(sum) * 8192 + (64'd1 << 29)) >> 30;
            if (v > HALF) begin
                v = HALF;
            end
            sine_table[i] = v[ROM_W-1:0];
        end
    end

    function automatic int table_index(int q);
        longint idx;
        idx = (longint'(q) * (SINE_ENTRIES - 1) + 2048) / 4096;
        if (idx > SINE_ENTRIES - 1) begin
            idx = SINE_ENTRIES - 1;
        end
        return int'(idx);
    endfunction

    // Odd symmetry for negative phases; fold magnitudes past one period.
    function automatic int table_sine(int phase);
        int m;
        int r;
        bit neg;
        neg = phase < 0;
        m   = neg ? -phase : phase;
        if (m > PERIOD) begin
            m = ((m - 1) % PERIOD) + 1;
        end
        if (m <= QUARTER) begin
            r = int'(sine_table[table_index(m)]);
        end else if (m <= HALF) begin
            r = int'(sine_table[SINE_ENTRIES - 1 - table_index(m - QUARTER)]);
        end else if (m <= THREE_Q) begin
            r = 0 - int'(sine_table[table_index(m - HALF)]);
        end else begin
            r = 0 - int'(sine_table[SINE_ENTRIES - 1 - table_index(m - THREE_Q)]);
        end
        return neg ? -r : r;
    endfunction

    function automatic logic signed [COIL_W-1:0] coil_level(int product);
        int c;
        c = product / HALF;
        if (c > 255) begin
            c = 255;
        end
        if (c < -255) begin
            c = -255;
        end
        return c[COIL_W-1:0];
    endfunction

    task automatic predict_coils(input int now, input int prev, input bit roll,
                                 input logic signed [TRQ_W-1:0] torque);
        int diff;
        int phase;
        int trq;
        coil_pair_t pair;
        trq           = torque;
        diff          = roll ? filtered_step : now - prev;
        filtered_step = (diff + filtered_step) / 2;
        phase         = POLE_PAIRS * (now - (null_angle + phase_trim) + 2 * filtered_step);
        pair.coil_a   = coil_level(-trq * table_sine(phase));
        pair.coil_b   = coil_level(trq * table_sine(QUARTER + phase));
        expected_coils.push_back(pair);
    endtask

    task automatic report_mismatch(input string what, input int got, input int wanted);
        if (n_fail < 40) begin
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, wanted);
        end
        n_fail++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_coils.delete();
            null_angle    = 0;
            phase_trim    = 0;
            filtered_step = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_NULL_ANGLE) begin
                    null_angle = int'(cfg_wdata);
                end else if (cfg_index == REG_PHASE_TRIM) begin
                    phase_trim = $signed(cfg_wdata);
                end
            end
            // Pop before push: a result can never belong to the item taken at this edge.
            if (m_tvalid && m_tready) begin
                if (expected_coils.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = expected_coils.pop_front();
                    if (m_tdata[COIL_W-1:0] !== want.coil_a) begin
                        report_mismatch("coil_a", $signed(m_tdata[COIL_W-1:0]), want.coil_a);
                    end
                    if (m_tdata[2*COIL_W-1:COIL_W] !== want.coil_b) begin
                        report_mismatch("coil_b", $signed(m_tdata[2*COIL_W-1:COIL_W]),
                                        want.coil_b);
                    end
                    if (m_tdata[M_TDATA_W-1:2*COIL_W] !== '0) begin
                        report_mismatch("tdata padding", int'(m_tdata[M_TDATA_W-1:2*COIL_W]), 0);
                    end
                    n_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_coils(int'(s_tdata[ANG_W-1:0]), int'(s_tdata[2*ANG_W-1:ANG_W]),
                              s_tuser[0], s_tdata[2*ANG_W+TRQ_W-1:2*ANG_W]);
            end
        end
        fail_count    <= n_fail;
        checked_count <= n_checked;
        pending_count <= expected_coils.size();
    end

    initial begin
        n_fail    = 0;
        n_checked = 0;
    end

endmodule

@@ sim/stepper_foc_phase_current_gen_core_test.sv @@
module stepper_foc_phase_current_gen_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sfpcg_pkg::*;

    localparam int POLE_PAIRS   = DEF_POLE_PAIRS;
    localparam int SINE_ENTRIES = DEF_SINE_ENTRIES;
    // Input transfer to m_tvalid when the output does not stall.
    localparam int LATENCY      = 8;
    // Watchdog bound, set well above the slowest legal run.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 230;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // [13:0] angle_now, [27:14] angle_before, [36:28] torque_level, rest zero
    logic [S_TDATA_W-1:0] s_tdata;
    // [0] rollover
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // [8:0] coil_a, [17:9] coil_b, rest zero
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    int fail_count;
    int checked_count;
    int pending_count;
    int cycle_count;
    int ticks_sent;
    int settings_used;
    // Percent chance of an idle burst: per tick sent on the input, per cycle on the result side.
    int send_idle_pct;
    int ready_idle_pct;

    stepper_foc_phase_current_gen_core #(
        .POLE_PAIRS  (POLE_PAIRS),
        .SINE_ENTRIES(SINE_ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    stepper_foc_coil_checker #(
        .POLE_PAIRS  (POLE_PAIRS),
        .SINE_ENTRIES(SINE_ENTRIES)
    ) coil_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .checked_count(checked_count),
        .pending_count(pending_count)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: drop m_tready for idle bursts at random.
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (ready_idle_pct != 0 && $urandom_range(0, 99) < ready_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Offer one tick and hold it until the transfer; then maybe idle for a burst.
    // tvalid stays high across back-to-back ticks, so it gets one assignment per step.
    task automatic send_tick(input int now, input int prev, input bit roll, input int torque);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, torque[TRQ_W-1:0], prev[ANG_W-1:0], now[ANG_W-1:0]};
        s_tuser  <= roll;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            // Scramble the idle bus so stale data is never mistaken for a tick.
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom(), $urandom()});
            s_tuser  <= S_TUSER_W'($urandom_range(0, 1));
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Hold off the input until every expected result has come back, then let
    // the pipeline settle before touching the registers.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    // Write both registers on two consecutive edges; the block must be idle.
    task automatic set_config(input logic [CFG_W-1:0] null_angle,
                              input logic [CFG_W-1:0] phase_trim);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_NULL_ANGLE;
        cfg_wdata <= null_angle;
        @(posedge aclk);
        cfg_index <= REG_PHASE_TRIM;
        cfg_wdata <= phase_trim;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    // Mostly a turning encoder: previous angle is the last one sent, rollover
    // is flagged on a wrap. The rest is stale rollovers and unrelated ticks.
    task automatic run_motion(input int count);
        int angle;
        int next;
        int vel;
        int pick;
        bit wrapped;
        angle = $urandom_range(0, PERIOD - 1);
        vel   = int'($urandom_range(0, 1600)) - 800;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                if ($urandom_range(0, 15) == 0) begin
                    vel = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 16000)) - 8000
                                                      : int'($urandom_range(0, 1600)) - 800;
                end
                next    = angle + vel + int'($urandom_range(0, 6)) - 3;
                wrapped = 1'b0;
                if (next < 0) begin
                    next    = next + PERIOD;
                    wrapped = 1'b1;
                end else if (next > PERIOD - 1) begin
                    next    = next - PERIOD;
                    wrapped = 1'b1;
                end
                send_tick(next, angle, wrapped, $urandom_range(0, 511));
                angle = next;
            end else if (pick < 82) begin
                send_tick($urandom_range(0, PERIOD - 1), $urandom_range(0, PERIOD - 1), 1'b1,
                          $urandom_range(0, 511));
            end else begin
                send_tick($urandom_range(0, PERIOD - 1), $urandom_range(0, PERIOD - 1),
                          $urandom_range(0, 1), $urandom_range(0, 511));
            end
        end
    endtask

    initial begin
        int idle_plan [6];
        idle_plan = '{25, 60, 0, 10, 40, 0};

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        ticks_sent     = 0;
        settings_used  = 1;
        send_idle_pct  = 20;
        ready_idle_pct = 20;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks at reset settings (null angle and trim both zero).
        send_tick(0, 0, 1'b0, 255);
        send_tick(0, 0, 1'b0, -255);
        send_tick(100, 100, 1'b0, 0);
        send_tick(1, 0, 1'b0, 1);
        send_tick(0, 1, 1'b0, -1);
        send_tick(4096, 4096, 1'b0, 255);
        send_tick(12288, 12288, 1'b0, 255);
        // Largest steps both ways; build the filtered step toward its limits.
        send_tick(16383, 0, 1'b0, 255);
        send_tick(16383, 0, 1'b0, 255);
        send_tick(16383, 0, 1'b0, -255);
        send_tick(16383, 0, 1'b0, 200);
        // Rollover keeps the filtered step instead of the raw difference.
        send_tick(16383, 16383, 1'b1, 100);
        send_tick(5, 16380, 1'b1, -100);
        send_tick(0, 16383, 1'b0, 255);
        send_tick(0, 16383, 1'b0, -255);
        send_tick(0, 16383, 1'b0, 255);
        send_tick(0, 16383, 1'b0, 77);
        send_tick(16380, 3, 1'b1, -200);
        // Torque of -256 lies outside the command range and must saturate.
        send_tick(16383, 16383, 1'b0, -256);
        send_tick(8192, 8191, 1'b0, -256);
        send_tick(2048, 2000, 1'b0, -256);
        send_tick(10000, 9990, 1'b0, 128);
        drain_results();

        // Random motion under a new setting per phase; the last has no idling.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(14'h3FFF, 14'h2000);
                1: set_config(14'h0000, 14'h1FFF);
                3: set_config(14'h3FFF, 14'h1FFF);
                5: set_config(14'h0000, 14'h2000);
                default: set_config(CFG_W'($urandom_range(0, PERIOD - 1)),
                                    CFG_W'($urandom_range(0, PERIOD - 1)));
            endcase
            send_idle_pct  = idle_plan[p];
            ready_idle_pct = (p == 5) ? 0 : idle_plan[(p + 2) % 6];
            run_motion(PHASE_ITEMS);
            drain_results();
        end

        $display("Sent %0d encoder ticks over %0d register settings, checked %0d coil pairs",
                 ticks_sent, settings_used, checked_count);
        $display("Mismatches: %0d, run length %0d cycles", fail_count, cycle_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
